// ----- rtl/core/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared constants, codes and types of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int HEAP_BYTES_DEF   = 65536;
	localparam int MAX_BLOCKS_DEF   = 64;
	localparam int HEADER_BYTES_DEF = 40;

	localparam int           LIMIT_W     = 17;
	localparam logic [16:0]  LIMIT_RESET = 17'h10000;
	localparam int           ADDR_W      = 16;
	localparam logic [15:0]  ADDR_MAX    = 16'hFFFF;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_BAD_FREE = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_FOUND,
		S_FREE_EVAL,
		S_MISS,
		S_SHIFT,
		S_DRAIN,
		S_WR0,
		S_WR1,
		S_RESP
	} state_t;

endpackage

// ----- rtl/core/ffha_ram.sv -----
// ----------------------------------------------------------------------------
// ffha_ram
// Block table memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module ffha_ram #(
	parameter int DEPTH = ffha_pkg::MAX_BLOCKS_DEF,
	parameter int IW    = $clog2(ffha_pkg::MAX_BLOCKS_DEF),
	parameter int DW    = 35
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [IW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/first_fit_heap_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over an address-ordered block table with split on
// allocate and coalesce on free. A request scans the live blocks, then moves
// table entries where a split or merge needs it and writes the table, before
// its result transfer is offered. One request is in work at a time, and the
// input accepts a new request once the result is registered. Reset empties
// the table by clearing the block count and heap end; no memory clearing
// pass is needed.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
	parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
	parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        cmd,
	input  logic [15:0] request_size,
	input  logic [15:0] free_address,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [15:0] data_address,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data
);

	localparam int HW = $clog2(HEAP_BYTES + 1);
	localparam int AW = (HW > 17) ? HW : 17;
	localparam int XW = AW + 2;
	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int EW = 2 * AW + 1;
	localparam logic [XW-1:0] HX  = XW'(HEADER_BYTES);
	localparam logic [AW-1:0] HA  = AW'(HEADER_BYTES);
	localparam logic [XW-1:0] SPX = XW'(HEADER_BYTES + 4);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

	ffha_pkg::state_t state_q, state_d;

	logic [16:0]   limit_q;
	logic          cmd_q;
	logic [AW-1:0] s_q;
	logic [15:0]   addr_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] heap_end_q;
	logic [CW-1:0] rd_idx_q;
	logic          chk_v_q;
	logic [IW-1:0] chk_idx_q;
	logic [IW-1:0] found_q;
	logic [EW-1:0] cur_q;
	logic [EW-1:0] prev_q;
	logic [IW-1:0] w0a_q, w1a_q;
	logic [EW-1:0] w0d_q, w1d_q;
	logic          w1v_q;
	logic [IW-1:0] sh_src_q, sh_end_q, pend_dst_q;
	logic          sh_up_q, pend_v_q;
	logic [1:0]    sh_off_q;
	logic [1:0]    rst_st_q;
	logic [15:0]   rst_addr_q;
	logic          out_v_q;
	logic [1:0]    status_q;
	logic [15:0]   daddr_q;

	logic          we;
	logic [IW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;

	ffha_ram #(.DEPTH(MAX_BLOCKS), .IW(IW), .DW(EW)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	logic [AW-1:0] r_start, r_size, c_start, c_size, p_start, p_size;
	logic          r_free, c_free, p_free;
	assign r_start = rdata[EW-1:AW+1];
	assign r_size  = rdata[AW:1];
	assign r_free  = rdata[0];
	assign c_start = cur_q[EW-1:AW+1];
	assign c_size  = cur_q[AW:1];
	assign c_free  = cur_q[0];
	assign p_start = prev_q[EW-1:AW+1];
	assign p_size  = prev_q[AW:1];
	assign p_free  = prev_q[0];

	logic          accept, out_free;
	logic          scan_issue, scan_hit, scan_end;
	logic [XW-1:0] lim;
	logic          miss_ok, spl, spl_shift;
	logic          pm, lastb, nf, fe_shift;
	logic [AW-1:0] base_start, base_size, fe_size;
	logic [1:0]    fe_r;
	logic [IW-1:0] fe_j;
	logic [CW-1:0] fe_src;

	assign accept   = req_valid && !req_stall;
	assign out_free = !out_v_q || !rsp_stall;

	assign scan_issue = rd_idx_q < count_q;
	assign scan_hit   = chk_v_q && ((cmd_q == ffha_pkg::CMD_ALLOC) ?
		(r_free && r_size >= s_q) :
		(XW'(r_start) + HX == XW'(addr_q)));
	assign scan_end   = chk_v_q && !scan_hit && (CW'(chk_idx_q) + CW'(1) == count_q);

	assign lim = (XW'(limit_q) < XW'(HEAP_BYTES)) ? XW'(limit_q) : XW'(HEAP_BYTES);
	assign miss_ok = (count_q < MAXC) && (XW'(heap_end_q) + HX + XW'(s_q) <= lim)
		&& (XW'(heap_end_q) + HX <= XW'(ffha_pkg::ADDR_MAX));

	assign spl       = (XW'(c_size) - XW'(s_q) >= SPX) && (count_q < MAXC);
	assign spl_shift = CW'(found_q) + CW'(2) <= count_q;

	assign pm         = (found_q != '0) && p_free;
	assign lastb      = !(CW'(found_q) + CW'(1) < count_q);
	assign nf         = r_free;
	assign base_start = pm ? p_start : c_start;
	assign base_size  = pm ? (p_size + HA + c_size) : c_size;
	assign fe_size    = nf ? (base_size + HA + r_size) : base_size;
	assign fe_r       = {1'b0, pm} + {1'b0, nf};
	assign fe_j       = pm ? (found_q - IW'(1)) : found_q;
	assign fe_src     = CW'(found_q) + CW'(1) + CW'(nf);
	assign fe_shift   = (fe_r != 2'd0) && (fe_src < count_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ffha_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (count_q == '0) ? ffha_pkg::S_MISS : ffha_pkg::S_SCAN;
				end
			end
			ffha_pkg::S_SCAN: begin
				if (scan_hit) begin
					state_d = ffha_pkg::S_FOUND;
				end else if (scan_end) begin
					state_d = ffha_pkg::S_MISS;
				end
			end
			ffha_pkg::S_FOUND: begin
				if (cmd_q == ffha_pkg::CMD_ALLOC) begin
					state_d = (spl && spl_shift) ? ffha_pkg::S_SHIFT : ffha_pkg::S_WR0;
				end else begin
					state_d = c_free ? ffha_pkg::S_RESP : ffha_pkg::S_FREE_EVAL;
				end
			end
			ffha_pkg::S_FREE_EVAL: begin
				if (lastb) begin
					state_d = ffha_pkg::S_RESP;
				end else begin
					state_d = fe_shift ? ffha_pkg::S_SHIFT : ffha_pkg::S_WR0;
				end
			end
			ffha_pkg::S_MISS: begin
				state_d = (cmd_q == ffha_pkg::CMD_ALLOC && miss_ok) ?
					ffha_pkg::S_WR0 : ffha_pkg::S_RESP;
			end
			ffha_pkg::S_SHIFT: begin
				if (sh_src_q == sh_end_q) begin
					state_d = ffha_pkg::S_DRAIN;
				end
			end
			ffha_pkg::S_DRAIN: state_d = ffha_pkg::S_WR0;
			ffha_pkg::S_WR0:   state_d = w1v_q ? ffha_pkg::S_WR1 : ffha_pkg::S_RESP;
			ffha_pkg::S_WR1:   state_d = ffha_pkg::S_RESP;
			ffha_pkg::S_RESP: begin
				if (out_free) begin
					state_d = ffha_pkg::S_IDLE;
				end
			end
			default: state_d = ffha_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != ffha_pkg::S_IDLE);
		we        = 1'b0;
		waddr     = w0a_q;
		wdata     = w0d_q;
		raddr     = '0;
		case (state_q)
			ffha_pkg::S_SCAN:  raddr = rd_idx_q[IW-1:0];
			ffha_pkg::S_FOUND: raddr = found_q + IW'(1);
			ffha_pkg::S_SHIFT: begin
				raddr = sh_src_q;
				we    = pend_v_q;
				waddr = pend_dst_q;
				wdata = rdata;
			end
			ffha_pkg::S_DRAIN: begin
				we    = pend_v_q;
				waddr = pend_dst_q;
				wdata = rdata;
			end
			ffha_pkg::S_WR0: we = 1'b1;
			ffha_pkg::S_WR1: begin
				we    = 1'b1;
				waddr = w1a_q;
				wdata = w1d_q;
			end
			default: ;
		endcase
	end

	assign cfg_ready    = 1'b1;
	assign rsp_valid    = out_v_q;
	assign status       = status_q;
	assign data_address = daddr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ffha_pkg::S_IDLE;
			limit_q    <= ffha_pkg::LIMIT_RESET;
			count_q    <= '0;
			heap_end_q <= '0;
			rd_idx_q   <= '0;
			chk_v_q    <= 1'b0;
			pend_v_q   <= 1'b0;
			w1v_q      <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
			if (state_q == ffha_pkg::S_RESP && out_free) begin
				out_v_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ffha_pkg::S_IDLE: begin
					if (accept) begin
						cmd_q    <= cmd;
						s_q      <= AW'(({1'b0, request_size} + 17'd3) & ~17'd3);
						addr_q   <= free_address;
						rd_idx_q <= '0;
						chk_v_q  <= 1'b0;
					end
				end
				ffha_pkg::S_SCAN: begin
					rd_idx_q  <= rd_idx_q + CW'(scan_issue);
					chk_v_q   <= scan_issue;
					chk_idx_q <= rd_idx_q[IW-1:0];
					if (chk_v_q) begin
						if (scan_hit) begin
							found_q <= chk_idx_q;
							cur_q   <= rdata;
						end else begin
							prev_q <= rdata;
						end
					end
				end
				ffha_pkg::S_FOUND: begin
					pend_v_q <= 1'b0;
					if (cmd_q == ffha_pkg::CMD_ALLOC) begin
						rst_st_q   <= ffha_pkg::ST_OK;
						rst_addr_q <= 16'(c_start + HA);
						w0a_q      <= found_q;
						if (spl) begin
							w0d_q    <= {c_start, s_q, 1'b0};
							w1v_q    <= 1'b1;
							w1a_q    <= found_q + IW'(1);
							w1d_q    <= {c_start + HA + s_q, c_size - s_q - HA, 1'b1};
							count_q  <= count_q + CW'(1);
							sh_src_q <= IW'(count_q - CW'(1));
							sh_end_q <= found_q + IW'(1);
							sh_up_q  <= 1'b1;
							sh_off_q <= 2'd1;
						end else begin
							w0d_q <= {c_start, c_size, 1'b0};
							w1v_q <= 1'b0;
						end
					end else begin
						rst_st_q   <= c_free ? ffha_pkg::ST_BAD_FREE : ffha_pkg::ST_OK;
						rst_addr_q <= '0;
					end
				end
				ffha_pkg::S_FREE_EVAL: begin
					w1v_q <= 1'b0;
					if (lastb) begin
						heap_end_q <= base_start;
						count_q    <= count_q - CW'(pm) - CW'(1);
					end else begin
						w0a_q    <= fe_j;
						w0d_q    <= {base_start, fe_size, 1'b1};
						count_q  <= count_q - CW'(fe_r);
						sh_src_q <= fe_src[IW-1:0];
						sh_end_q <= IW'(count_q - CW'(1));
						sh_up_q  <= 1'b0;
						sh_off_q <= fe_r;
					end
				end
				ffha_pkg::S_MISS: begin
					rst_addr_q <= '0;
					w1v_q      <= 1'b0;
					if (cmd_q == ffha_pkg::CMD_FREE) begin
						rst_st_q <= ffha_pkg::ST_BAD_FREE;
					end else if (miss_ok) begin
						rst_st_q   <= ffha_pkg::ST_OK;
						rst_addr_q <= 16'(heap_end_q + HA);
						w0a_q      <= count_q[IW-1:0];
						w0d_q      <= {heap_end_q, s_q, 1'b0};
						count_q    <= count_q + CW'(1);
						heap_end_q <= heap_end_q + HA + s_q;
					end else begin
						rst_st_q <= ffha_pkg::ST_NO_SPACE;
					end
				end
				ffha_pkg::S_SHIFT: begin
					pend_v_q   <= 1'b1;
					pend_dst_q <= sh_up_q ? (sh_src_q + IW'(1)) : (sh_src_q - IW'(sh_off_q));
					sh_src_q   <= sh_up_q ? (sh_src_q - IW'(1)) : (sh_src_q + IW'(1));
				end
				ffha_pkg::S_DRAIN: begin
					pend_v_q <= 1'b0;
				end
				ffha_pkg::S_RESP: begin
					if (out_free) begin
						status_q <= rst_st_q;
						daddr_q  <= rst_addr_q;
					end
				end
				default: ;
			endcase
		end
	end

endmodule
